[rtl/core/soc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_pkg: shared types and constants
// Types, opcode codes and limits for the output script classifier.
// ----------------------------------------------------------------------------
package soc_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int MAX_OPS     = 20;
    localparam int EARLY_OPS   = 5;
    localparam int HASH_BYTES  = 20;
    localparam int KEY_MIN     = 33;
    localparam int KEY_MAX     = 120;
    localparam int MULTI_MAX   = 16 + 3;

    localparam logic [7:0] OP_0               = 8'h00;
    localparam logic [7:0] OP_LEN1            = 8'h4c;
    localparam logic [7:0] OP_LEN2            = 8'h4d;
    localparam logic [7:0] OP_LEN4            = 8'h4e;
    localparam logic [7:0] OP_1               = 8'h51;
    localparam logic [7:0] OP_16              = 8'h60;
    localparam logic [7:0] OP_DUP             = 8'h76;
    localparam logic [7:0] OP_SAME            = 8'h87;
    localparam logic [7:0] OP_SAME_CHECK      = 8'h88;
    localparam logic [7:0] OP_HASH20          = 8'ha9;
    localparam logic [7:0] OP_SIG_CHECK       = 8'hac;
    localparam logic [7:0] OP_MULTI_SIG_CHECK = 8'hae;

    localparam logic [2:0] CLS_NONSTD   = 3'd0;
    localparam logic [2:0] CLS_PKH      = 3'd1;
    localparam logic [2:0] CLS_SH       = 3'd2;
    localparam logic [2:0] CLS_PK       = 3'd3;
    localparam logic [2:0] CLS_MULTISIG = 3'd4;

    typedef enum logic [1:0] {
        PH_OP   = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef struct packed {
        logic [2:0]   script_class;
        logic         truncated;
        logic         hash_found;
        logic [159:0] hash;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

[rtl/core/soc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_front: script parser and classifier
// Splits script bytes into operations and forms one result on the last byte.
// ----------------------------------------------------------------------------
module soc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_script_byte,
    input  logic             i_last_byte,
    output logic             o_push,
    output soc_pkg::t_result o_result
);

    soc_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_lbl, n_lbl;
    logic [31:0] r_plen, n_plen;
    logic [31:0] r_dbl, n_dbl;
    logic [4:0]  r_opc, n_opc;
    logic [7:0]  r_eop [soc_pkg::EARLY_OPS];
    logic [7:0]  n_eop [soc_pkg::EARLY_OPS];
    logic [soc_pkg::EARLY_OPS-1:0] r_etw, n_etw;
    logic [9:0]  r_tail [2];
    logic [9:0]  n_tail [2];
    logic        r_mak, n_mak;
    logic [7:0]  r_hash [soc_pkg::HASH_BYTES];
    logic [7:0]  n_hash [soc_pkg::HASH_BYTES];

    function automatic logic small_int(input logic [7:0] op);
        small_int = (op == soc_pkg::OP_0) ||
                    (op >= soc_pkg::OP_1 && op <= soc_pkg::OP_16);
    endfunction

    always_comb begin
        logic [31:0] len;
        logic        mark;
        logic        key;
        logic        tw;
        logic [4:0]  idx;
        n_phase = r_phase;
        n_lbl   = r_lbl;
        n_plen  = r_plen;
        n_dbl   = r_dbl;
        n_opc   = r_opc;
        n_eop   = r_eop;
        n_etw   = r_etw;
        n_tail  = r_tail;
        n_mak   = r_mak;
        n_hash  = r_hash;
        len     = 32'd0;
        mark    = 1'b0;
        key     = 1'b0;
        tw      = 1'b0;
        idx     = 5'd0;
        unique case (r_phase)
            soc_pkg::PH_OP: begin
                if (r_opc >= 5'd3) n_mak = r_mak & r_tail[0][8];
                n_tail[0] = r_tail[1];
                n_tail[1] = {2'b00, i_script_byte};
                if (r_opc < 5'(soc_pkg::EARLY_OPS)) begin
                    n_eop[r_opc[2:0]] = i_script_byte;
                    n_etw[r_opc[2:0]] = 1'b0;
                end
                if (r_opc < 5'(soc_pkg::MAX_OPS)) n_opc = r_opc + 5'd1;
                if (i_script_byte < soc_pkg::OP_LEN1) begin
                    len  = {24'd0, i_script_byte};
                    mark = 1'b1;
                end else if (i_script_byte <= soc_pkg::OP_LEN4) begin
                    n_phase = soc_pkg::PH_LEN;
                    n_lbl   = (i_script_byte == soc_pkg::OP_LEN1) ? 3'd1 :
                              (i_script_byte == soc_pkg::OP_LEN2) ? 3'd2 : 3'd4;
                    n_plen  = 32'd0;
                    n_dbl   = 32'd0;
                end
            end
            soc_pkg::PH_LEN: begin
                if (r_dbl < 32'd32) n_plen = r_plen | ({24'd0, i_script_byte} << r_dbl[4:0]);
                n_dbl = r_dbl + 32'd8;
                if (r_lbl != 3'd0) n_lbl = r_lbl - 3'd1;
                if (n_lbl == 3'd0) begin
                    if ((n_plen >> soc_pkg::LENGTH_BITS) != 32'd0) begin
                        n_phase = soc_pkg::PH_SKIP;
                        n_dbl   = 32'd0;
                    end else begin
                        len  = n_plen;
                        mark = 1'b1;
                    end
                end
            end
            soc_pkg::PH_DATA: begin
                if (r_opc == 5'd3 && r_etw[2] && r_dbl <= 32'd20) begin
                    idx = 5'(32'd20 - r_dbl);
                    if (idx < 5'(soc_pkg::HASH_BYTES)) n_hash[idx] = i_script_byte;
                end
                n_dbl = r_dbl - 32'd1;
                if (n_dbl == 32'd0) n_phase = soc_pkg::PH_OP;
            end
            default: begin
            end
        endcase
        if (mark) begin
            key = (len >= 32'(soc_pkg::KEY_MIN)) && (len <= 32'(soc_pkg::KEY_MAX));
            tw  = (len == 32'(soc_pkg::HASH_BYTES));
            n_tail[1] = n_tail[1] | {tw, key, 8'd0};
            if (n_opc >= 5'd1 && n_opc <= 5'(soc_pkg::EARLY_OPS))
                n_etw[3'(n_opc - 5'd1)] = tw;
            n_dbl   = len;
            n_phase = (len != 32'd0) ? soc_pkg::PH_DATA : soc_pkg::PH_OP;
        end
    end

    always_comb begin
        logic trunc;
        logic bad;
        logic found;
        trunc = (n_phase == soc_pkg::PH_LEN) ||
                (n_phase == soc_pkg::PH_DATA && n_dbl != 32'd0);
        bad   = trunc || (n_phase == soc_pkg::PH_SKIP);
        o_result.script_class = soc_pkg::CLS_NONSTD;
        if (!bad) begin
            if (n_opc == 5'd5 && n_eop[0] == soc_pkg::OP_DUP &&
                n_eop[1] == soc_pkg::OP_HASH20 && n_etw[2] &&
                n_eop[3] == soc_pkg::OP_SAME_CHECK && n_eop[4] == soc_pkg::OP_SIG_CHECK)
                o_result.script_class = soc_pkg::CLS_PKH;
            else if (n_opc == 5'd3 && n_eop[0] == soc_pkg::OP_HASH20 && n_etw[1] &&
                     n_eop[2] == soc_pkg::OP_SAME)
                o_result.script_class = soc_pkg::CLS_SH;
            else if (n_opc == 5'd2 && n_tail[0][8] && n_tail[1][7:0] == soc_pkg::OP_SIG_CHECK)
                o_result.script_class = soc_pkg::CLS_PK;
            else if (n_opc >= 5'd3 && n_opc <= 5'(soc_pkg::MULTI_MAX) &&
                     small_int(n_eop[0]) && small_int(n_tail[0][7:0]) &&
                     n_tail[1][7:0] == soc_pkg::OP_MULTI_SIG_CHECK && n_mak)
                o_result.script_class = soc_pkg::CLS_MULTISIG;
        end
        found = (n_opc >= 5'd3) && n_etw[2] &&
                !(trunc && n_phase == soc_pkg::PH_DATA && n_opc == 5'd3);
        o_result.truncated  = trunc;
        o_result.hash_found = found;
        for (int i = 0; i < soc_pkg::HASH_BYTES; i++) begin
            o_result.hash[159-8*i -: 8] = found ? n_hash[i] : 8'd0;
        end
        o_push = i_take && i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_phase <= soc_pkg::PH_OP;
            r_lbl   <= 3'd0;
            r_plen  <= 32'd0;
            r_dbl   <= 32'd0;
            r_opc   <= 5'd0;
            for (int i = 0; i < soc_pkg::EARLY_OPS; i++) r_eop[i] <= 8'd0;
            r_etw   <= '0;
            r_tail[0] <= 10'd0;
            r_tail[1] <= 10'd0;
            r_mak   <= 1'b1;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_lbl   <= n_lbl;
            r_plen  <= n_plen;
            r_dbl   <= n_dbl;
            r_opc   <= n_opc;
            r_eop   <= n_eop;
            r_etw   <= n_etw;
            r_tail  <= n_tail;
            r_mak   <= n_mak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_hash <= n_hash;
    end

endmodule

[rtl/core/soc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_queue: two-entry result queue
// Decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module soc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  soc_pkg::t_result  i_data,
    input  logic              i_pop,
    output soc_pkg::t_result  o_data,
    output soc_pkg::t_q_flags o_flags
);

    soc_pkg::t_result r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_data        = r_mem[r_rptr];
    assign o_flags.full  = (r_count == 2'd2);
    assign o_flags.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

endmodule

[rtl/core/soc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_back: output stage
// Holds one result on the output channel until it is taken.
// ----------------------------------------------------------------------------
module soc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  soc_pkg::t_q_flags i_flags,
    input  soc_pkg::t_result  i_data,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [2:0]        o_script_class,
    output logic              o_truncated,
    output logic              o_hash_found,
    output logic [63:0]       o_hash_upper,
    output logic [63:0]       o_hash_middle,
    output logic [31:0]       o_hash_lower
);

    logic             r_valid;
    soc_pkg::t_result r_res;

    assign o_pop          = !i_flags.empty && (!r_valid || !i_stall);
    assign o_valid        = r_valid;
    assign o_script_class = r_res.script_class;
    assign o_truncated    = r_res.truncated;
    assign o_hash_found   = r_res.hash_found;
    assign o_hash_upper   = r_res.hash[159:96];
    assign o_hash_middle  = r_res.hash[95:32];
    assign o_hash_lower   = r_res.hash[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_flags.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_data;
    end

endmodule

[rtl/core/script_output_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_output_classifier_top: output script classifier
// Parses an output script byte by byte and reports its class on the last byte.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   script   | in        | i_valid / o_stall  | i_script_byte, i_last_byte
//   result   | out       | o_valid / i_stall  | o_script_class .. o_hash_lower
//
// One byte per cycle while o_stall is low; the parser registers update in the cycle of the transfer.
// After the edge that takes its last byte, a result passes through a two-entry
// queue and then the output register before it shows on o_valid.
// o_stall rises only when the queue is full. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module script_output_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_script_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_script_class,
    output logic        o_truncated,
    output logic        o_hash_found,
    output logic [63:0] o_hash_upper,
    output logic [63:0] o_hash_middle,
    output logic [31:0] o_hash_lower
);

    logic              take;
    logic              push;
    logic              pop;
    soc_pkg::t_result  fr_res;
    soc_pkg::t_result  q_res;
    soc_pkg::t_q_flags q_flags;

    assign o_stall = q_flags.full;
    assign take    = i_valid && !o_stall;

    soc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_script_byte (i_script_byte),
        .i_last_byte   (i_last_byte),
        .o_push        (push),
        .o_result      (fr_res)
    );

    soc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_res),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_flags (q_flags)
    );

    soc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flags        (q_flags),
        .i_data         (q_res),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_script_class (o_script_class),
        .o_truncated    (o_truncated),
        .o_hash_found   (o_hash_found),
        .o_hash_upper   (o_hash_upper),
        .o_hash_middle  (o_hash_middle),
        .o_hash_lower   (o_hash_lower)
    );

    a_class_not_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_script_class != soc_pkg::CLS_NONSTD |-> !o_truncated)
        else $error("classified script reported truncated");

    a_hash_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hash_found |-> o_hash_upper == 64'd0 && o_hash_middle == 64'd0 &&
        o_hash_lower == 32'd0)
        else $error("hash not cleared without a hash push");

    a_pkh_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_script_class == soc_pkg::CLS_PKH |-> o_hash_found)
        else $error("pubkey hash class without hash");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_flags.full || pop)
        else $error("result pushed into full queue");

endmodule
